@@ rtl/core/sal_pkg.sv @@
`default_nettype none

package sal_pkg;

   // Page and address geometry of the layout.
   localparam int PAGE_BITS = 12;
   localparam int ADDR_BITS = 32;

   typedef logic [ADDR_BITS-1:0] addr_type;

   localparam addr_type PAGE_SIZE = addr_type'(1) << PAGE_BITS;
   // Mask that keeps the header size modulo the page size.
   localparam logic [11:0] HDR_MASK = 12'((64'd1 << PAGE_BITS) - 64'd1);

   // Bit positions inside the packed section flags.
   localparam int FL_LOAD  = 0;
   localparam int FL_NOTE  = 1;
   localparam int FL_BSS   = 2;
   localparam int FL_WRITE = 3;
   localparam int FL_READ  = 4;
   localparam int FL_EXEC  = 5;

   // Permission groups that trigger the data and bss origin jumps.
   localparam logic [5:0] GRP_DATA = 6'b011001;
   localparam logic [5:0] GRP_BSS  = 6'b011101;

   typedef enum logic [2:0] {
      CSR_TEXT_ORIGIN = 3'd0,
      CSR_DATA_ORIGIN = 3'd1,
      CSR_BSS_ORIGIN  = 3'd2,
      CSR_HEADER_SIZE = 3'd3,
      CSR_IMPURE_MODE = 3'd4,
      CSR_IGNORE_EXEC = 3'd5
   } csr_index_type;

   typedef struct packed {
      addr_type    text_origin;
      addr_type    data_origin;
      addr_type    bss_origin;
      logic [11:0] header_size;
      logic        impure_mode;
      logic        ignore_exec;
   } cfg_type;

   typedef struct packed {
      addr_type   next_address;
      logic [5:0] previous_flags;
      logic       pass_started;
      logic       first_group_pending;
      logic       data_jump_pending;
      logic       bss_jump_pending;
      addr_type   text_end_mark;
      addr_type   data_end_mark;
      addr_type   bss_start_mark;
   } pass_state_type;

   typedef struct packed {
      logic [5:0]  flags;
      logic [4:0]  align_log2;
      logic [31:0] section_size;
      logic        last_section;
   } section_type;

   typedef struct packed {
      addr_type section_address;
      logic     summary_valid;
      addr_type text_end;
      addr_type data_end;
      addr_type bss_begin;
      addr_type image_end;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/sal_step.sv @@
`default_nettype none

// Places one section: computes its address and the pass state that follows it.
module sal_step
   import sal_pkg::*;
(
   input  cfg_type        cfg,
   input  pass_state_type st,
   input  section_type    sec,
   output pass_state_type st_nxt,
   output result_type     res
);

   addr_type   pos_start;
   addr_type   pos_jump;
   addr_type   pos_round;
   addr_type   pos_page;
   addr_type   pos_end;
   addr_type   amask;
   logic [5:0] raw;
   logic [5:0] grp;
   logic [5:0] grp_nobss;
   logic       same_page;

   always_comb begin
      raw = sec.flags;
      pos_start = st.pass_started ? st.next_address
                                  : cfg.text_origin + addr_type'(cfg.header_size & HDR_MASK);
      st_nxt = st;
      st_nxt.pass_started = 1'b1;
      st_nxt.next_address = pos_start;

      grp = raw;
      if (cfg.ignore_exec) begin
         grp[FL_EXEC] = 1'b0;
      end
      if (cfg.impure_mode) begin
         grp[FL_WRITE] = 1'b1;
      end

      // Origin jumps at the first data or bss group.
      pos_jump = pos_start;
      if (grp != st.previous_flags) begin
         if (grp == GRP_DATA && st.data_jump_pending && cfg.data_origin != '0) begin
            pos_jump = cfg.data_origin;
         end
         if (grp == GRP_BSS && st.bss_jump_pending && cfg.bss_origin != '0) begin
            pos_jump = cfg.bss_origin;
         end
      end

      amask = ~({ADDR_BITS{1'b1}} << sec.align_log2);
      pos_round = (pos_jump + amask) & ~amask;

      grp_nobss = grp;
      grp_nobss[FL_BSS] = 1'b0;
      same_page = (pos_round[ADDR_BITS-1:PAGE_BITS] == pos_start[ADDR_BITS-1:PAGE_BITS]) &&
                  (pos_round[PAGE_BITS-1:0] != '0);
      pos_page = pos_round;
      if (grp_nobss != st.previous_flags && same_page && !st.first_group_pending) begin
         pos_page = pos_round + PAGE_SIZE;
      end
      pos_end = pos_page + addr_type'(sec.section_size);

      res.section_address = '0;
      if (!raw[FL_LOAD]) begin
         st_nxt.previous_flags = raw;
      end else begin
         if ((raw[FL_EXEC] != st.previous_flags[FL_EXEC]) && st.text_end_mark == '0) begin
            st_nxt.text_end_mark = pos_start;
         end
         if ((raw[FL_BSS] != st.previous_flags[FL_BSS]) && st.data_end_mark == '0) begin
            st_nxt.data_end_mark = pos_start;
         end
         if (grp != st.previous_flags) begin
            if (grp == GRP_DATA && st.data_jump_pending && cfg.data_origin != '0) begin
               st_nxt.data_jump_pending = 1'b0;
            end
            if (grp == GRP_BSS && st.bss_jump_pending) begin
               st_nxt.bss_jump_pending = 1'b0;
               if (cfg.bss_origin == '0) begin
                  st_nxt.bss_start_mark = pos_start;
               end
            end
         end
         if (grp_nobss != st.previous_flags && same_page) begin
            st_nxt.first_group_pending = 1'b0;
         end
         res.section_address = pos_page;
         st_nxt.previous_flags = grp_nobss;
         st_nxt.next_address = pos_end;
      end

      res.summary_valid = 1'b0;
      res.text_end = '0;
      res.data_end = '0;
      res.bss_begin = '0;
      res.image_end = '0;
      if (sec.last_section) begin
         res.summary_valid = 1'b1;
         res.text_end = (st_nxt.text_end_mark != '0) ? st_nxt.text_end_mark
                                                     : st_nxt.next_address;
         res.data_end = (st_nxt.data_end_mark != '0) ? st_nxt.data_end_mark
                                                     : st_nxt.next_address;
         res.bss_begin = (cfg.bss_origin != '0) ? cfg.bss_origin : st_nxt.bss_start_mark;
         res.image_end = st_nxt.next_address;
         // The pass ends here; the next beat starts a fresh one.
         st_nxt.pass_started = 1'b0;
         st_nxt.previous_flags = '0;
         st_nxt.first_group_pending = 1'b1;
         st_nxt.data_jump_pending = 1'b1;
         st_nxt.bss_jump_pending = 1'b1;
         st_nxt.text_end_mark = '0;
         st_nxt.data_end_mark = '0;
         st_nxt.bss_start_mark = '0;
         st_nxt.next_address = '0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/section_address_layout.sv @@
`default_nettype none

// Channel   Direction  Beat contents
// req_      in         tdata: section flags, alignment, size; tlast: last section of a pass
// rsp_      out        tdata: address and end values; tuser: end values valid
// csr_      in         write enable, register index, 32-bit write data
//
// Each section is placed by a single step of combinational logic from the
// request handshake into the response register, and the running pass state
// updates on the same edge. A new beat is accepted every cycle as long as
// the response register is empty or being drained, so throughput is one
// section per clock; the response is registered.
// Reset is synchronous and clears the configuration and the pass state.
// A stalled response holds its beat and stalls the request side with it.
module section_address_layout
   import sal_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_tvalid,
   output      logic          req_tready,
   // [0] loadable, [1] is_note, [2] is_bss, [3] can_write, [4] can_read,
   // [5] can_exec, [10:6] align_log2, [42:11] section_size, [47:43] zero
   input  wire logic [47:0]   req_tdata,
   input  wire logic          req_tlast,    // last_section

   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // [31:0] section_address, [63:32] text_end, [95:64] data_end,
   // [127:96] bss_begin, [159:128] image_end
   output      logic [159:0]  rsp_tdata,
   output      logic          rsp_tuser,    // summary_valid

   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   pass_state_type state_ff, state_in;
   pass_state_type state_step;
   section_type    sec;
   result_type     res;
   result_type     rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_accept;

   // The response register is the only buffer; it frees up as it drains.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign sec.flags        = req_tdata[5:0];
   assign sec.align_log2   = req_tdata[10:6];
   assign sec.section_size = req_tdata[42:11];
   assign sec.last_section = req_tlast;

   sal_step u_step (
      .cfg    (cfg_ff),
      .st     (state_ff),
      .sec    (sec),
      .st_nxt (state_step),
      .res    (res)
   );

   // Configuration writes; an index outside the register list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TEXT_ORIGIN: cfg_in.text_origin = addr_type'(csr_wdata);
            CSR_DATA_ORIGIN: cfg_in.data_origin = addr_type'(csr_wdata);
            CSR_BSS_ORIGIN:  cfg_in.bss_origin  = addr_type'(csr_wdata);
            CSR_HEADER_SIZE: cfg_in.header_size = csr_wdata[11:0];
            CSR_IMPURE_MODE: cfg_in.impure_mode = csr_wdata[0];
            CSR_IGNORE_EXEC: cfg_in.ignore_exec = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = req_accept ? state_step : state_ff;
      rsp_in       = req_accept ? res : rsp_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                       <= '0;
         rsp_valid_ff                 <= 1'b0;
         state_ff.pass_started        <= 1'b0;
         state_ff.previous_flags      <= '0;
         state_ff.first_group_pending <= 1'b1;
         state_ff.data_jump_pending   <= 1'b1;
         state_ff.bss_jump_pending    <= 1'b1;
         state_ff.text_end_mark       <= '0;
         state_ff.data_end_mark       <= '0;
         state_ff.bss_start_mark      <= '0;
         state_ff.next_address        <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.summary_valid;
   assign rsp_tdata  = {rsp_ff.image_end, rsp_ff.bss_begin, rsp_ff.data_end,
                        rsp_ff.text_end, rsp_ff.section_address};

   // An accepted section always yields a response beat on the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_accept |=> rsp_tvalid)
      else $error("accepted section produced no response");

   // The last section of a pass closes it.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> !state_ff.pass_started && state_ff.first_group_pending)
      else $error("pass state not cleared after last section");

   // A non-loadable section gets address zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tdata[FL_LOAD]) |=> rsp_tdata[31:0] == '0)
      else $error("non-loadable section got an address");

   // End values are zero unless the summary flag is set.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tdata[159:32] == '0)
      else $error("end values present without summary");

endmodule

`default_nettype wire
